// ===== src/segment_allocator_fit_policy_assert.svh =====
// Assertion macros shared by the segment allocator RTL.
// No dependencies; the macros are empty when SYNTHESIS is defined.
`ifndef SEGMENT_ALLOCATOR_FIT_POLICY_ASSERT_SVH
`define SEGMENT_ALLOCATOR_FIT_POLICY_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define SFP_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define SFP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
// Invariant that holds on every rising edge.
`define SFP_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error(msg);
`else
`define SFP_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg)
`define SFP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`define SFP_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg)
`endif

`endif

// ===== src/sfp_pkg.sv =====
// Package for the segment allocator: codes, item structs and table entry type.
// Used by every module of the block but sfp_ram; depends on nothing.
package sfp_pkg;

    localparam int DATA_W           = 16;
    localparam int HOLE_W           = 6;
    localparam int MAX_SEGMENTS_DEF = 32;
    localparam logic [DATA_W-1:0] TOTAL_RESET = 16'hFFFF;

    // Register indexes on the configuration port.
    localparam logic REG_TOTAL  = 1'b0;
    localparam logic REG_POLICY = 1'b1;

    // Byte addresses of the registers on the configuration port.
    localparam logic [2:0] ADDR_TOTAL  = 3'd0;
    localparam logic [2:0] ADDR_POLICY = 3'd4;

    // Placement rules; the spare code behaves as first fit.
    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;
    localparam logic [1:0] POL_SPARE = 2'd3;

    // Request codes; the spare code changes nothing.
    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_FREE  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    // Reply status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BADSIZE  = 3'd1;
    localparam logic [2:0] ST_NOFIT    = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_EX,
        S_MOVE_RD,
        S_MOVE_WR,
        S_PUT,
        S_CNT_RD,
        S_CNT_EX,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]        action;
        logic [DATA_W-1:0] request_size;
        logic [DATA_W-1:0] segment_start;
    } cmd_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [DATA_W-1:0] granted_address;
        logic [DATA_W-1:0] units_free;
        logic [HOLE_W-1:0] gap_count;
    } result_t;

    typedef struct packed {
        logic [DATA_W-1:0] base;
        logic [DATA_W-1:0] length;
    } entry_t;

    // Result of the shared gap unit.
    typedef struct packed {
        logic [DATA_W:0] len;
        logic            nonempty;
        logic            fits;
    } gap_t;

endpackage

// ===== src/segment_allocator_fit_policy.sv =====
// Segment allocator with first, best or worst fit over an address-sorted table.
// Clear, unused and rejected requests raise the result strobe in the cycle after acceptance;
// allocate scans the table, moves entries, writes the new one and recounts the gaps; free scans,
// moves entries and recounts, each entry going through the single read port and the shared gap unit.
// Throughput: one item at a time; busy stays high through the result strobe cycle.
// Reset: asynchronous, active low; the table is empty and free units equal total_size.
module segment_allocator_fit_policy #(
    parameter int MAX_SEGMENTS = sfp_pkg::MAX_SEGMENTS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  sfp_pkg::cmd_t    cmd,
    output logic             done,
    output sfp_pkg::result_t result,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import sfp_pkg::*;

    `include "segment_allocator_fit_policy_assert.svh"

    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int AW = $clog2(MAX_SEGMENTS);
    localparam int EW = $bits(entry_t);

    state_t state_reg, state_next;

    logic [DATA_W-1:0] total_reg, total_next;
    logic [1:0]        policy_reg, policy_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [DATA_W-1:0] free_reg, free_next;
    logic [HOLE_W-1:0] holes_reg, holes_next;

    logic [1:0]        action_reg, action_next;
    logic [DATA_W-1:0] size_reg, size_next;
    logic [DATA_W-1:0] addr_reg, addr_next;
    logic [2:0]        status_reg, status_next;
    logic [DATA_W-1:0] granted_reg, granted_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [DATA_W:0]   prev_end_reg, prev_end_next;
    logic              found_reg, found_next;
    logic [CW-1:0]     pick_reg, pick_next;
    logic [DATA_W:0]   pick_len_reg, pick_len_next;
    logic [DATA_W:0]   pick_start_reg, pick_start_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    entry_t        ram_wdata;
    entry_t        rd_entry;
    logic [CW-1:0] raddr_full;

    logic            cfg_we;
    logic            is_alloc;
    logic            bad_size;
    logic            at_end;
    logic [DATA_W:0] gap_end;
    logic [DATA_W:0] entry_end;
    gap_t            gap;
    logic            better;
    logic            take;
    logic            first_style;
    logic            alloc_stop;
    logic            free_hit;
    logic            more_moves;

    // Table storage.
    sfp_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_SEGMENTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rd_entry)
    );

    // Shared gap arithmetic.
    sfp_gap_unit u_gap (
        .gap_end   (gap_end),
        .gap_start (prev_end_reg),
        .need      (size_reg),
        .res       (gap)
    );

    // Decision terms used by both the sequencer and the datapath.
    always_comb
    begin
        cfg_we      = psel && penable && pwrite;
        is_alloc    = action_reg == ACT_ALLOC;
        bad_size    = (cmd.request_size == '0) || (cmd.request_size > free_reg);
        at_end      = idx_reg >= count_reg;
        gap_end     = at_end ? {1'b0, total_reg} : {1'b0, rd_entry.base};
        entry_end   = {1'b0, rd_entry.base} + {1'b0, rd_entry.length};
        better      = !found_reg
                      || ((policy_reg == POL_BEST) && (gap.len < pick_len_reg))
                      || ((policy_reg == POL_WORST) && (gap.len > pick_len_reg));
        take        = gap.fits && better;
        first_style = (policy_reg != POL_BEST) && (policy_reg != POL_WORST);
        alloc_stop  = at_end || (gap.fits && first_style);
        free_hit    = !at_end && (rd_entry.base == addr_reg);
        more_moves  = is_alloc ? (idx_reg > pick_reg) : ((idx_reg + 1'b1) < count_reg);
    end

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (cmd.action == ACT_ALLOC)
                    begin
                        if (bad_size || (count_reg >= CW'(MAX_SEGMENTS)))
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_SCAN_RD;
                        end
                    end
                    else if (cmd.action == ACT_FREE)
                    begin
                        state_next = S_SCAN_RD;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_EX;
            end
            S_SCAN_EX:
            begin
                if (is_alloc)
                begin
                    if (alloc_stop)
                    begin
                        state_next = (found_reg || take) ? S_MOVE_RD : S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN_RD;
                    end
                end
                else if (at_end)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = free_hit ? S_MOVE_RD : S_SCAN_RD;
                end
            end
            S_MOVE_RD:
            begin
                if (more_moves)
                begin
                    state_next = S_MOVE_WR;
                end
                else
                begin
                    state_next = is_alloc ? S_PUT : S_CNT_RD;
                end
            end
            S_MOVE_WR:
            begin
                state_next = S_MOVE_RD;
            end
            S_PUT:
            begin
                state_next = S_CNT_RD;
            end
            S_CNT_RD:
            begin
                state_next = at_end ? S_DONE : S_CNT_EX;
            end
            S_CNT_EX:
            begin
                state_next = S_CNT_RD;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and output logic of the sequencer.
    always_comb
    begin
        total_next      = total_reg;
        policy_next     = policy_reg;
        count_next      = count_reg;
        free_next       = free_reg;
        holes_next      = holes_reg;
        action_next     = action_reg;
        size_next       = size_reg;
        addr_next       = addr_reg;
        status_next     = status_reg;
        granted_next    = granted_reg;
        idx_next        = idx_reg;
        prev_end_next   = prev_end_reg;
        found_next      = found_reg;
        pick_next       = pick_reg;
        pick_len_next   = pick_len_reg;
        pick_start_next = pick_start_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg[AW-1:0];
        ram_wdata       = rd_entry;
        raddr_full      = idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    action_next   = cmd.action;
                    size_next     = cmd.request_size;
                    addr_next     = cmd.segment_start;
                    status_next   = ST_OK;
                    granted_next  = '0;
                    idx_next      = '0;
                    prev_end_next = '0;
                    found_next    = 1'b0;
                    if (cmd.action == ACT_ALLOC)
                    begin
                        if (bad_size)
                        begin
                            status_next = ST_BADSIZE;
                        end
                        else if (count_reg >= CW'(MAX_SEGMENTS))
                        begin
                            status_next = ST_FULL;
                        end
                    end
                    else if (cmd.action == ACT_CLEAR)
                    begin
                        count_next = '0;
                        free_next  = total_reg;
                        holes_next = '0;
                    end
                end
            end
            S_SCAN_EX:
            begin
                if (is_alloc)
                begin
                    if (take)
                    begin
                        found_next      = 1'b1;
                        pick_next       = idx_reg;
                        pick_len_next   = gap.len;
                        pick_start_next = prev_end_reg;
                    end
                    prev_end_next = entry_end;
                    if (alloc_stop)
                    begin
                        idx_next = count_reg;
                        if (!(found_reg || take))
                        begin
                            status_next = ST_NOFIT;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else if (at_end)
                begin
                    status_next = ST_NOTFOUND;
                end
                else if (free_hit)
                begin
                    free_next = free_reg + rd_entry.length;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_MOVE_RD:
            begin
                raddr_full = is_alloc ? (idx_reg - 1'b1) : (idx_reg + 1'b1);
                if (!more_moves && !is_alloc)
                begin
                    count_next    = count_reg - 1'b1;
                    idx_next      = '0;
                    prev_end_next = '0;
                    holes_next    = '0;
                end
            end
            S_MOVE_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg[AW-1:0];
                ram_wdata = rd_entry;
                idx_next  = is_alloc ? (idx_reg - 1'b1) : (idx_reg + 1'b1);
            end
            S_PUT:
            begin
                ram_we           = 1'b1;
                ram_waddr        = pick_reg[AW-1:0];
                ram_wdata.base   = pick_start_reg[DATA_W-1:0];
                ram_wdata.length = size_reg;
                granted_next     = pick_start_reg[DATA_W-1:0];
                count_next       = count_reg + 1'b1;
                free_next        = free_reg - size_reg;
                idx_next         = '0;
                prev_end_next    = '0;
                holes_next       = '0;
            end
            S_CNT_EX:
            begin
                if ((idx_reg != '0) && gap.nonempty)
                begin
                    holes_next = holes_reg + 1'b1;
                end
                prev_end_next = entry_end;
                idx_next      = idx_reg + 1'b1;
            end
            default:
            begin
            end
        endcase

        // Register writes; the user must issue them only while idle, which the block does not enforce.
        if (cfg_we)
        begin
            if (paddr[2] == REG_TOTAL)
            begin
                total_next = pwdata[DATA_W-1:0];
                count_next = '0;
                free_next  = pwdata[DATA_W-1:0];
                holes_next = '0;
            end
            else
            begin
                policy_next = pwdata[1:0];
            end
        end

        ram_raddr = raddr_full[AW-1:0];
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            total_reg  <= TOTAL_RESET;
            policy_reg <= POL_FIRST;
            count_reg  <= '0;
            free_reg   <= TOTAL_RESET;
            holes_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            total_reg  <= total_next;
            policy_reg <= policy_next;
            count_reg  <= count_next;
            free_reg   <= free_next;
            holes_reg  <= holes_next;
        end
    end

    // Per-item working registers.
    always_ff @(posedge clk)
    begin
        action_reg     <= action_next;
        size_reg       <= size_next;
        addr_reg       <= addr_next;
        status_reg     <= status_next;
        granted_reg    <= granted_next;
        idx_reg        <= idx_next;
        prev_end_reg   <= prev_end_next;
        found_reg      <= found_next;
        pick_reg       <= pick_next;
        pick_len_reg   <= pick_len_next;
        pick_start_reg <= pick_start_next;
    end

    // Ports.
    always_comb
    begin
        busy                   = state_reg != S_IDLE;
        done                   = state_reg == S_DONE;
        result.status          = status_reg;
        result.granted_address = granted_reg;
        result.units_free      = free_reg;
        result.gap_count       = holes_reg;
        pready                 = 1'b1;
        if (paddr[2] == REG_TOTAL)
        begin
            prdata = {{(32 - DATA_W){1'b0}}, total_reg};
        end
        else
        begin
            prdata = {30'b0, policy_reg};
        end
    end

    `SFP_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted item did not raise busy")
    `SFP_ASSERT_NEXT(a_done_idle, clk, rst_n, done, !busy, "sequencer did not return to idle after the result")
    `SFP_ASSERT_ALWAYS(a_count_range, clk, rst_n, count_reg <= CW'(MAX_SEGMENTS), "segment count beyond table depth")
    `SFP_ASSERT_ALWAYS(a_free_range, clk, rst_n, free_reg <= total_reg, "free units exceed total size")
    `SFP_ASSERT_IMPLIES(a_grant_zero, clk, rst_n, done && (status_reg != ST_OK), granted_reg == '0, "address granted on a failed request")

endmodule

// ===== src/sfp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sfp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/sfp_gap_unit.sv =====
// Shared gap unit: length of the hole between two addresses and its tests.
// Depends on sfp_pkg.
module sfp_gap_unit (
    input  logic [sfp_pkg::DATA_W:0]   gap_end,
    input  logic [sfp_pkg::DATA_W:0]   gap_start,
    input  logic [sfp_pkg::DATA_W-1:0] need,
    output sfp_pkg::gap_t              res
);
    import sfp_pkg::*;

    // Clamp to zero when the end does not lie past the start.
    always_comb
    begin
        res.nonempty = gap_end > gap_start;
        res.len      = res.nonempty ? (gap_end - gap_start) : '0;
        res.fits     = res.len >= {1'b0, need};
    end

endmodule

// ===== dv/segment_allocator_checker.sv =====
// Checker for the segment allocator: tracks register writes and accepted requests,
// predicts each reply and compares it with the strobed result.
// Depends on sfp_pkg for the item structs and the codes.
`timescale 1ns / 100ps

module segment_allocator_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  sfp_pkg::cmd_t    cmd,
    input  logic             done,
    input  sfp_pkg::result_t result,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    input  logic             pready,
    output int               fail_count,
    output int               replies_pending
);
    import sfp_pkg::*;

    localparam int TABLE_DEPTH = MAX_SEGMENTS_DEF;

    // Shadow copy of the configuration and the segment table.
    int unsigned mem_units;
    logic [1:0]  placement;
    int unsigned seg_addr [TABLE_DEPTH];
    int unsigned seg_size [TABLE_DEPTH];
    int unsigned seg_used;
    int unsigned units_left;

    result_t expected_replies[$];

    // Length of the gap that precedes table position pos.
    function automatic int unsigned hole_len(int unsigned pos);
        int unsigned s;
        int unsigned e;
        s = (pos == 0) ? 0 : seg_addr[pos-1] + seg_size[pos-1];
        e = (pos < seg_used) ? seg_addr[pos] : mem_units;
        return (e > s) ? e - s : 0;
    endfunction

    // Applies one request to the shadow table and returns the reply it should give.
    function automatic result_t serve_request(cmd_t c);
        int unsigned i;
        int unsigned pick;
        int unsigned pick_len;
        int unsigned len;
        int unsigned holes;
        bit          found;
        bit          hit;
        result_t     r;
        r = '0;
        r.status = ST_OK;
        found = 0;
        pick = 0;
        pick_len = 0;
        hit = 0;
        if (c.action == ACT_ALLOC) begin
            if (c.request_size == 0 || c.request_size > units_left)
                r.status = ST_BADSIZE;
            else if (seg_used >= TABLE_DEPTH)
                r.status = ST_FULL;
            else
            begin
                for (i = 0; i <= seg_used; i++)
                begin
                    len = hole_len(i);
                    if (len >= c.request_size && !hit)
                    begin
                        if (!found)
                        begin
                            found = 1;
                            pick = i;
                            pick_len = len;
                            if (placement != POL_BEST && placement != POL_WORST)
                                hit = 1;
                        end
                        else if ((placement == POL_BEST && len < pick_len) ||
                                 (placement == POL_WORST && len > pick_len))
                        begin
                            pick = i;
                            pick_len = len;
                        end
                    end
                end
                if (!found)
                    r.status = ST_NOFIT;
                else
                begin
                    r.granted_address = (pick == 0) ? 16'd0 :
                        16'(seg_addr[pick-1] + seg_size[pick-1]);
                    for (i = seg_used; i > pick; i--)
                    begin
                        seg_addr[i] = seg_addr[i-1];
                        seg_size[i] = seg_size[i-1];
                    end
                    seg_addr[pick] = r.granted_address;
                    seg_size[pick] = c.request_size;
                    seg_used++;
                    units_left -= c.request_size;
                end
            end
        end
        else if (c.action == ACT_FREE)
        begin
            for (i = 0; i < seg_used && !found; i++)
                if (seg_addr[i] == c.segment_start)
                begin
                    found = 1;
                    pick = i;
                end
            if (!found)
                r.status = ST_NOTFOUND;
            else
            begin
                units_left += seg_size[pick];
                for (i = pick; i + 1 < seg_used; i++)
                begin
                    seg_addr[i] = seg_addr[i+1];
                    seg_size[i] = seg_size[i+1];
                end
                seg_used--;
            end
        end
        else if (c.action == ACT_CLEAR)
        begin
            seg_used = 0;
            units_left = mem_units;
        end
        holes = 0;
        for (i = 1; i < seg_used; i++)
            if (hole_len(i) > 0)
                holes++;
        r.units_free = 16'(units_left);
        r.gap_count = 6'(holes);
        return r;
    endfunction

    assign replies_pending = expected_replies.size();

    // Register writes, accepted requests and strobed replies, all seen at the rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            mem_units = 65535;
            placement = POL_FIRST;
            seg_used = 0;
            units_left = 65535;
            fail_count = 0;
            expected_replies.delete();
        end
        else
        begin
            if (done)
            begin
                if (expected_replies.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected reply %p", $realtime, result);
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (want.status !== result.status ||
                        want.granted_address !== result.granted_address ||
                        want.units_free !== result.units_free ||
                        want.gap_count !== result.gap_count)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: reply mismatch: expected %p, got %p",
                                     $realtime, want, result);
                    end
                end
            end
            if (start && !busy)
                expected_replies.push_back(serve_request(cmd));
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == ADDR_TOTAL)
                begin
                    mem_units = pwdata[15:0];
                    seg_used = 0;
                    units_left = mem_units;
                end
                else if (paddr == ADDR_POLICY)
                    placement = pwdata[1:0];
            end
        end
    end

endmodule

// ===== dv/tb.sv =====
// Top of the segment allocator testbench: clock, reset, request and register stimulus.
// Depends on sfp_pkg, segment_allocator_fit_policy and segment_allocator_checker.
`timescale 1ns / 100ps

module tb;
    import sfp_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    cmd_t        cmd;
    logic        done;
    result_t     result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          replies_pending;

    int unsigned      cur_total;
    int               items_sent;
    logic [1:0]       last_action;
    logic [15:0]      live_bases[$];

    segment_allocator_fit_policy uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .done(done), .result(result), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    segment_allocator_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .done(done), .result(result), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .pready(pready),
        .fail_count(fail_count), .replies_pending(replies_pending)
    );

    always #4 clk = ~clk;

    // Tracks granted bases so that most frees name a live segment.
    always @(posedge clk)
    begin
        if (start && !busy)
            last_action = cmd.action;
        if (done && result.status == ST_OK && last_action == ACT_ALLOC)
            live_bases.push_back(result.granted_address);
    end

    initial
    begin
        #50ms;
        $display("Regression FAIL");
        $finish;
    end

    // Offers one item and holds it until the block accepts it.
    task automatic send_item(logic [1:0] act, logic [15:0] size, logic [15:0] base,
                             bit may_idle);
        @(negedge clk);
        while (may_idle && $urandom_range(99) < 38)
        begin
            start = 0;
            @(negedge clk);
        end
        start = 1;
        cmd.action = act;
        cmd.request_size = size;
        cmd.segment_start = base;
        // Busy only changes at the rising edge, so a low value here means acceptance next edge.
        while (busy)
            @(negedge clk);
        @(posedge clk);
        items_sent++;
    endtask

    // Drops start and waits until every reply has come back.
    task automatic drain;
        @(negedge clk);
        start = 0;
        wait (replies_pending == 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] value);
        drain();
        psel = 1;
        pwrite = 1;
        paddr = addr;
        pwdata = value;
        @(negedge clk);
        penable = 1;
        @(negedge clk);
        psel = 0;
        penable = 0;
        if (addr == ADDR_TOTAL)
        begin
            cur_total = value[15:0];
            live_bases.delete();
        end
    endtask

    task automatic random_item(bit may_idle);
        int unsigned pick;
        int unsigned sel;
        logic [15:0] size;
        logic [15:0] base;
        pick = $urandom_range(99);
        size = 16'($urandom);
        base = 16'($urandom);
        if (pick < 55)
        begin
            sel = $urandom_range(9);
            if (sel < 7)
                size = 16'($urandom_range(1, (cur_total / 10 > 1) ? cur_total / 10 : 1));
            else if (sel == 7)
                size = 16'($urandom_range(0, cur_total));
            else if (sel == 8)
                size = 0;
            send_item(ACT_ALLOC, size, base, may_idle);
        end
        else if (pick < 92)
        begin
            if (live_bases.size() > 0 && $urandom_range(9) < 8)
            begin
                sel = $urandom_range(live_bases.size() - 1);
                base = live_bases[sel];
                live_bases.delete(sel);
            end
            else if ($urandom_range(1))
                base = 16'($urandom_range(0, cur_total));
            send_item(ACT_FREE, size, base, may_idle);
        end
        else if (pick < 96)
        begin
            live_bases.delete();
            send_item(ACT_CLEAR, size, base, may_idle);
        end
        else
            send_item(ACT_NONE, size, base, may_idle);
    endtask

    initial
    begin
        int unsigned totals[8];
        int unsigned policies[8];
        int i;
        int p;
        totals = '{65535, 100, 64, 1000, 40, 65535, 1, 300};
        policies = '{POL_FIRST, POL_BEST, POL_WORST, POL_SPARE, POL_BEST, POL_WORST,
                     POL_FIRST, POL_FIRST};
        clk = 0;
        rst_n = 0;
        start = 0;
        cmd = '0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        cur_total = 65535;
        items_sent = 0;
        last_action = ACT_CLEAR;
        repeat (12) @(negedge clk);
        rst_n = 1;

        // Directed: size extremes, unknown address, freeing the head, clear, unused action.
        send_item(ACT_ALLOC, 16'd0, 16'hFFFF, 0);
        send_item(ACT_ALLOC, 16'hFFFF, 16'd0, 0);
        send_item(ACT_ALLOC, 16'd1, 16'd0, 0);
        send_item(ACT_FREE, 16'd0, 16'd5, 0);
        send_item(ACT_FREE, 16'hFFFF, 16'd0, 0);
        send_item(ACT_ALLOC, 16'd100, 16'd0, 0);
        send_item(ACT_ALLOC, 16'd200, 16'd0, 0);
        send_item(ACT_ALLOC, 16'd300, 16'd0, 0);
        send_item(ACT_FREE, 16'd0, 16'd0, 0);
        send_item(ACT_FREE, 16'd0, 16'd300, 0);
        send_item(ACT_ALLOC, 16'd50, 16'd0, 0);
        send_item(ACT_NONE, 16'hFFFF, 16'hFFFF, 0);
        send_item(ACT_CLEAR, 16'd0, 16'd0, 0);

        // Directed: fill the table with one-unit segments until it is full.
        write_reg(ADDR_TOTAL, 32'd33);
        write_reg(ADDR_POLICY, 32'(POL_BEST));
        for (i = 0; i < 32; i++)
            send_item(ACT_ALLOC, 16'd1, 16'd0, 1);
        send_item(ACT_ALLOC, 16'd1, 16'd0, 0);
        send_item(ACT_ALLOC, 16'd5, 16'd0, 0);
        send_item(ACT_FREE, 16'd0, 16'd10, 0);
        send_item(ACT_ALLOC, 16'd2, 16'd0, 0);
        write_reg(ADDR_TOTAL, 32'd0);
        send_item(ACT_ALLOC, 16'd1, 16'd0, 0);
        write_reg(ADDR_TOTAL, 32'hFFFF_FFFF);
        write_reg(ADDR_POLICY, 32'hFFFF_FFFF);
        live_bases.delete();

        // Random phases over several register settings.
        for (p = 0; p < 8; p++)
        begin
            write_reg(ADDR_TOTAL, totals[p]);
            write_reg(ADDR_POLICY, policies[p]);
            for (i = 0; i < 75; i++)
            begin
                random_item(!(p == 3));
                if (p == 5 && i == 30)
                    drain();
            end
        end

        drain();
        repeat (250) @(posedge clk);
        if (fail_count == 0 && replies_pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
